// ===== rtl/core/ppba_pkg.sv =====
// Package for the paged pool block allocator: state encoding, status and
// register codes, sizing constants and the block count clamp.
// No dependencies.
`timescale 1ns / 1ps

package ppba_pkg;

    localparam int MAX_PAGES    = 16;
    localparam int MAX_BLOCKS   = 256;
    localparam int HEADER_BYTES = 16;

    localparam int PAGE_W   = $clog2(MAX_PAGES);
    localparam int BLK_W    = $clog2(MAX_BLOCKS);
    localparam int PCNT_W   = $clog2(MAX_PAGES + 1);
    localparam int BCNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int HANDLE_W = 12;
    localparam int OFFS_W   = 21;
    localparam int PAY_W    = 13;
    localparam int STRIDE_W = PAY_W + 1;
    localparam int PROD_W   = BLK_W + STRIDE_W;
    localparam int LINK_W   = BLK_W + 1;
    localparam int TOTAL    = MAX_PAGES * MAX_BLOCKS;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUT_OF  = 2'd1;
    localparam logic [1:0] ST_BAD_HDL = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] REG_PAYLOAD = 2'd0;
    localparam logic [1:0] REG_BPP     = 2'd1;
    localparam logic [1:0] REG_MULTI   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MAKE,
        S_POP,
        S_POPW,
        S_FREE,
        S_DONE
    } t_state;

    function automatic logic [BCNT_W-1:0] clamp_blocks(input logic [8:0] bpp);
        logic [BCNT_W-1:0] n;
        if (bpp == 9'd0) begin
            n = BCNT_W'(1);
        end else if ({23'd0, bpp} > MAX_BLOCKS) begin
            n = BCNT_W'(MAX_BLOCKS);
        end else begin
            n = BCNT_W'(bpp);
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/paged_pool_block_allocator_unit.sv =====
// Top level of the paged pool block allocator: sequencer, page head table,
// configuration registers and result register.
// Depends on ppba_pkg and ppba_ram.
`timescale 1ns / 1ps

// Channel    Direction  Handshake                   Word
// input      in         i_in_valid / o_in_stall     i_op, i_handle_in
// output     out        o_out_valid / i_out_stall   o_status, o_handle_out,
//                                                   o_byte_offset, o_page_total
// config     in         psel, penable, pwrite       paddr, pwdata, prdata
//
// A free passes through S_FREE and S_DONE to the result register; an allocate scans the
// page heads and, when none is free, links the blocks of a new page (up to 256), then
// passes through S_POP, S_POPW and S_DONE; with no block left it goes to S_DONE instead.
// Reset clears the control state and needs no clearing pass over the RAM.
// A stalled output holds its word; the next word is taken while it waits, and the input
// stalls from acceptance until its result is loaded.

module paged_pool_block_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [ppba_pkg::HANDLE_W-1:0] i_handle_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [ppba_pkg::HANDLE_W-1:0] o_handle_out,
    output logic [ppba_pkg::OFFS_W-1:0]   o_byte_offset,
    output logic [ppba_pkg::PCNT_W-1:0]   o_page_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int PW = ppba_pkg::PAGE_W;
    localparam int BW = ppba_pkg::BLK_W;

    ppba_pkg::t_state r_state, n_state;

    logic [ppba_pkg::PAY_W-1:0]  r_payload;
    logic [8:0]                  r_bpp;
    logic                        r_multi;

    logic [PW-1:0]                 r_page, n_page;
    logic [BW-1:0]                 r_blk, n_blk;
    logic [BW-1:0]                 r_cnt, n_cnt;
    logic [ppba_pkg::PCNT_W-1:0]   r_pages, n_pages;
    logic [1:0]                    r_status, n_status;
    logic [ppba_pkg::PROD_W-1:0]   r_prod, n_prod;
    logic                          r_op, n_op;

    logic [BW-1:0]                 r_free_head   [ppba_pkg::MAX_PAGES];
    logic                          r_head_valid  [ppba_pkg::MAX_PAGES];
    logic [ppba_pkg::BCNT_W-1:0]   r_page_blocks [ppba_pkg::MAX_PAGES];

    logic                          r_out_valid;
    logic [1:0]                    r_out_status;
    logic [ppba_pkg::HANDLE_W-1:0] r_out_handle;
    logic [ppba_pkg::OFFS_W-1:0]   r_out_offset;
    logic [ppba_pkg::PCNT_W-1:0]   r_out_pages;

    logic                          head_we;
    logic [BW-1:0]                 head_blk;
    logic                          head_vld;
    logic                          pb_we;
    logic                          out_load;
    logic                          in_acc;
    logic                          cfg_we;
    logic                          make_last;
    logic [ppba_pkg::BCNT_W-1:0]   make_n;
    logic [ppba_pkg::BCNT_W-1:0]   cnt_inc;

    logic                          ram_we;
    logic [PW+BW-1:0]              ram_waddr;
    logic [ppba_pkg::LINK_W-1:0]   ram_wdata;
    logic [PW+BW-1:0]              ram_raddr;
    logic [ppba_pkg::LINK_W-1:0]   ram_rdata;

    ppba_ram #(
        .WIDTH(ppba_pkg::LINK_W),
        .DEPTH(ppba_pkg::TOTAL)
    ) u_links (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ppba_pkg::S_IDLE);
    assign cfg_we     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign make_n     = ppba_pkg::clamp_blocks(r_bpp);
    assign cnt_inc    = ppba_pkg::BCNT_W'(r_cnt) + ppba_pkg::BCNT_W'(1);
    assign make_last  = (cnt_inc >= make_n);
    assign ram_raddr  = {r_page, r_free_head[r_page]};

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            ppba_pkg::REG_PAYLOAD: prdata = 32'(r_payload);
            ppba_pkg::REG_BPP:     prdata = 32'(r_bpp);
            ppba_pkg::REG_MULTI:   prdata = 32'(r_multi);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload <= ppba_pkg::PAY_W'(64);
            r_bpp     <= 9'd256;
            r_multi   <= 1'b1;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                ppba_pkg::REG_PAYLOAD: r_payload <= pwdata[ppba_pkg::PAY_W-1:0];
                ppba_pkg::REG_BPP:     r_bpp     <= pwdata[8:0];
                ppba_pkg::REG_MULTI:   r_multi   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_page    = r_page;
        n_blk     = r_blk;
        n_cnt     = r_cnt;
        n_pages   = r_pages;
        n_status  = r_status;
        n_prod    = r_prod;
        n_op      = r_op;
        head_we   = 1'b0;
        head_blk  = '0;
        head_vld  = 1'b0;
        pb_we     = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {r_page, r_cnt};
        ram_wdata = '0;
        unique case (r_state)
            ppba_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_op;
                    n_blk    = i_handle_in[BW-1:0];
                    n_status = ppba_pkg::ST_OK;
                    n_prod   = '0;
                    if (i_op == ppba_pkg::OP_FREE) begin
                        n_page  = i_handle_in[PW+BW-1:BW];
                        n_state = ppba_pkg::S_FREE;
                    end else if (r_pages == '0) begin
                        n_page  = '0;
                        n_cnt   = '0;
                        n_state = ppba_pkg::S_MAKE;
                    end else begin
                        n_page  = PW'(r_pages - ppba_pkg::PCNT_W'(1));
                        n_state = ppba_pkg::S_SCAN;
                    end
                end
            end
            ppba_pkg::S_SCAN: begin
                if (r_head_valid[r_page]) begin
                    n_state = ppba_pkg::S_POP;
                end else if (r_page == '0) begin
                    if (r_multi && (r_pages < ppba_pkg::PCNT_W'(ppba_pkg::MAX_PAGES))) begin
                        n_page  = r_pages[PW-1:0];
                        n_cnt   = '0;
                        n_state = ppba_pkg::S_MAKE;
                    end else begin
                        n_status = ppba_pkg::ST_OUT_OF;
                        n_state  = ppba_pkg::S_DONE;
                    end
                end else begin
                    n_page = r_page - PW'(1);
                end
            end
            ppba_pkg::S_MAKE: begin
                ram_we    = 1'b1;
                ram_waddr = {r_page, r_cnt};
                ram_wdata = make_last ? '0 : {1'b1, cnt_inc[BW-1:0]};
                n_cnt     = cnt_inc[BW-1:0];
                if (make_last) begin
                    head_we  = 1'b1;
                    head_blk = '0;
                    head_vld = 1'b1;
                    pb_we    = 1'b1;
                    n_pages  = r_pages + ppba_pkg::PCNT_W'(1);
                    n_state  = ppba_pkg::S_POP;
                end
            end
            ppba_pkg::S_POP: begin
                n_blk   = r_free_head[r_page];
                n_state = ppba_pkg::S_POPW;
            end
            ppba_pkg::S_POPW: begin
                head_we  = 1'b1;
                head_blk = ram_rdata[BW-1:0];
                head_vld = ram_rdata[BW];
                n_prod   = ppba_pkg::PROD_W'(r_blk)
                           * ppba_pkg::PROD_W'(ppba_pkg::STRIDE_W'(r_payload)
                           + ppba_pkg::STRIDE_W'(ppba_pkg::HEADER_BYTES));
                n_state  = ppba_pkg::S_DONE;
            end
            ppba_pkg::S_FREE: begin
                if ((ppba_pkg::PCNT_W'(r_page) < r_pages)
                    && (ppba_pkg::BCNT_W'(r_blk) < r_page_blocks[r_page])) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_page, r_blk};
                    ram_wdata = {r_head_valid[r_page], r_free_head[r_page]};
                    head_we   = 1'b1;
                    head_blk  = r_blk;
                    head_vld  = 1'b1;
                end else begin
                    n_status = ppba_pkg::ST_BAD_HDL;
                end
                n_state = ppba_pkg::S_DONE;
            end
            ppba_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ppba_pkg::S_IDLE;
                end
            end
            default: n_state = ppba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppba_pkg::S_IDLE;
            r_pages <= '0;
        end else begin
            r_state <= n_state;
            r_pages <= n_pages;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page   <= n_page;
        r_blk    <= n_blk;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_prod   <= n_prod;
        r_op     <= n_op;
        if (head_we) begin
            r_free_head[r_page]  <= head_blk;
            r_head_valid[r_page] <= head_vld;
        end
        if (pb_we) begin
            r_page_blocks[r_page] <= make_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_pages  <= r_pages;
            if ((r_op == ppba_pkg::OP_ALLOC) && (r_status == ppba_pkg::ST_OK)) begin
                r_out_handle <= ppba_pkg::HANDLE_W'({r_page, r_blk});
                r_out_offset <= r_prod[ppba_pkg::OFFS_W-1:0]
                                + ppba_pkg::OFFS_W'(ppba_pkg::HEADER_BYTES);
            end else begin
                r_out_handle <= '0;
                r_out_offset <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_handle_out  = r_out_handle;
    assign o_byte_offset = r_out_offset;
    assign o_page_total  = r_out_pages;

    a_pages_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages <= ppba_pkg::PCNT_W'(ppba_pkg::MAX_PAGES))
        else $error("page count beyond the pool size");

    a_make_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppba_pkg::S_MAKE) |-> (r_pages < ppba_pkg::PCNT_W'(ppba_pkg::MAX_PAGES)))
        else $error("page creation with the pool already full");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ppba_pkg::S_DONE))
        else $error("result word raised outside the completion state");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3))
        else $error("undefined status code on the result word");

    a_pop_page_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppba_pkg::S_POP) |-> (ppba_pkg::PCNT_W'(r_page) < r_pages))
        else $error("pop from a page that was never created");

endmodule

// ===== rtl/core/ppba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps

module ppba_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
